@@ hdl/rsdp_pkg.sv @@
`default_nettype none

package rsdp_pkg;

    localparam int unsigned OFFSET_BITS_DEF = 17;
    localparam int unsigned ALIGN_BYTES     = 16;
    localparam int unsigned ALIGN_LOG2      = $clog2(ALIGN_BYTES);
    localparam int unsigned TRACKERS        = 3;

    localparam int unsigned MATCH_W = 17;
    localparam int unsigned REL_CMP_W = 33;

    localparam int unsigned SIG_LEN = 8;
    localparam int unsigned V1_LEN  = 20;
    localparam int unsigned V2_LEN  = 36;
    localparam int unsigned REV_POS = 15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic               found;
        logic [MATCH_W-1:0] match_offset;
        logic [7:0]         revision;
    } t_out_req;

    // Completion status of one tracker cell for the current byte.
    typedef struct packed {
        logic hit;
        logic late;
    } t_cell_hit;

    // Signature "RSD PTR " indexed by byte position.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h52;
            3'd1:    b = 8'h53;
            3'd2:    b = 8'h44;
            3'd3:    b = 8'h20;
            3'd4:    b = 8'h50;
            3'd5:    b = 8'h54;
            3'd6:    b = 8'h52;
            3'd7:    b = 8'h20;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hdl/acpi_rsdp_stream_scanner.sv @@
`default_nettype none

// Scans a memory region, one byte per request, for the first 16-byte-aligned
// ACPI root pointer ("RSD PTR " signature, zero checksum over bytes 0..19 and,
// for a nonzero revision, zero extended checksum over bytes 20..35). A match
// yields one result with found set, its offset and revision; the rest of the
// region is then skipped. A region without a match yields one result with
// found clear on its last byte. One byte is taken per cycle while o_stall is
// low, and bytes may follow back to back: three tracker cells, passing the
// start token around a ring, each follow one overlapping candidate in
// parallel. The result for the deciding byte is registered in a two-entry
// output buffer, which keeps input flowing while the consumer stalls.
module acpi_rsdp_stream_scanner #(
    parameter int unsigned OFFSET_BITS = rsdp_pkg::OFFSET_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rsdp_pkg::t_in_req  i_in,
    output logic               o_valid,
    input  logic               i_stall,
    output rsdp_pkg::t_out_req o_out
);
    import rsdp_pkg::*;

    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_match_done;

    logic                   accept;
    logic                   en;
    logic                   adv;
    logic                   wrap;
    logic                   kill;
    logic                   any_hit;
    logic                   buf_full;
    logic                   res_valid;
    t_out_req               res;

    logic [TRACKERS-1:0]    tok;
    t_cell_hit              hits  [TRACKERS];
    logic [OFFSET_BITS-1:0] bases [TRACKERS];
    logic [7:0]             revs  [TRACKERS];

    assign accept = i_valid && !buf_full;
    assign en     = accept && !r_match_done;
    assign adv    = accept && (r_pos[ALIGN_LOG2-1:0] == ALIGN_LOG2'(ALIGN_BYTES - 1));
    assign wrap   = accept && (i_in.last_byte || (&r_pos));
    assign kill   = accept && (i_in.last_byte || any_hit);

    for (genvar g = 0; g < TRACKERS; g++) begin : g_cell
        rsdp_cell #(
            .OFFSET_BITS(OFFSET_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_first    (g == 0),
            .i_en       (en),
            .i_adv      (adv),
            .i_wrap     (wrap),
            .i_kill     (kill),
            .i_tok_prev (tok[(g + TRACKERS - 1) % TRACKERS]),
            .i_pos      (r_pos),
            .i_data     (i_in.data_byte),
            .o_tok      (tok[g]),
            .o_hit      (hits[g]),
            .o_base     (bases[g]),
            .o_rev      (revs[g])
        );
    end

    // A candidate finishing its extended checksum started earlier than one
    // finishing the short form on the same byte, so it takes priority.
    always_comb begin
        logic sel_late;
        sel_late         = 1'b0;
        any_hit          = 1'b0;
        res.found        = 1'b0;
        res.match_offset = '0;
        res.revision     = 8'd0;
        for (int t = TRACKERS - 1; t >= 0; t--) begin
            if (hits[t].hit && !hits[t].late && !sel_late) begin
                any_hit          = 1'b1;
                res.found        = 1'b1;
                res.match_offset = MATCH_W'(bases[t]);
                res.revision     = revs[t];
            end
        end
        for (int t = TRACKERS - 1; t >= 0; t--) begin
            if (hits[t].hit && hits[t].late) begin
                sel_late         = 1'b1;
                any_hit          = 1'b1;
                res.found        = 1'b1;
                res.match_offset = MATCH_W'(bases[t]);
                res.revision     = revs[t];
            end
        end
        res_valid = en && (any_hit || i_in.last_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_match_done <= 1'b0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_pos        <= '0;
                r_match_done <= 1'b0;
            end else begin
                r_pos <= r_pos + 1'b1;
                if (any_hit) begin
                    r_match_done <= 1'b1;
                end
            end
        end
    end

    rsdp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (buf_full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

    assign o_stall = buf_full;

endmodule

`default_nettype wire

@@ hdl/rsdp_cell.sv @@
`default_nettype none

module rsdp_cell #(
    parameter int unsigned OFFSET_BITS = rsdp_pkg::OFFSET_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_first,
    input  logic                      i_en,
    input  logic                      i_adv,
    input  logic                      i_wrap,
    input  logic                      i_kill,
    input  logic                      i_tok_prev,
    input  logic [OFFSET_BITS-1:0]    i_pos,
    input  logic [7:0]                i_data,
    output logic                      o_tok,
    output rsdp_pkg::t_cell_hit       o_hit,
    output logic [OFFSET_BITS-1:0]    o_base,
    output logic [7:0]                o_rev
);
    import rsdp_pkg::*;

    localparam logic [REL_CMP_W-1:0] REL_SIG  = REL_CMP_W'(SIG_LEN);
    localparam logic [REL_CMP_W-1:0] REL_REV  = REL_CMP_W'(REV_POS);
    localparam logic [REL_CMP_W-1:0] REL_V1   = REL_CMP_W'(V1_LEN - 1);
    localparam logic [REL_CMP_W-1:0] REL_V2   = REL_CMP_W'(V2_LEN - 1);
    localparam logic [REL_CMP_W-1:0] REL_STOP = REL_CMP_W'(V2_LEN);

    logic                   r_tok;
    logic                   r_active;
    logic [OFFSET_BITS-1:0] r_base;
    logic                   r_sig_ok;
    logic [7:0]             r_sum;
    logic [7:0]             r_rev;

    logic                   start;
    logic                   cur_act;
    logic [OFFSET_BITS-1:0] cur_base;
    logic                   cur_sig;
    logic [7:0]             cur_sum;
    logic [7:0]             cur_rev;
    logic [OFFSET_BITS-1:0] rel;
    logic [REL_CMP_W-1:0]   rel_x;
    logic                   n_active;
    logic                   n_sig_ok;
    logic [7:0]             n_sum;
    logic [7:0]             n_rev;
    logic                   hit;
    logic                   late;

    always_comb begin
        start    = i_en && r_tok && (i_pos[ALIGN_LOG2-1:0] == '0);
        cur_act  = start || r_active;
        cur_base = start ? i_pos : r_base;
        cur_sig  = start ? 1'b1 : r_sig_ok;
        cur_sum  = start ? 8'd0 : r_sum;
        cur_rev  = start ? 8'd0 : r_rev;
        rel      = i_pos - cur_base;
        rel_x    = REL_CMP_W'(rel);

        n_active = cur_act;
        n_sig_ok = cur_sig;
        n_sum    = cur_sum;
        n_rev    = cur_rev;
        hit      = 1'b0;
        late     = 1'b0;

        if (cur_act) begin
            if (rel_x >= REL_STOP) begin
                n_active = 1'b0;
            end else begin
                if (rel_x < REL_SIG && i_data != sig_byte(rel[2:0])) begin
                    n_sig_ok = 1'b0;
                end
                n_sum = cur_sum + i_data;
                if (rel_x == REL_REV) begin
                    n_rev = i_data;
                end
                if (rel_x == REL_V1) begin
                    if (!n_sig_ok || n_sum != 8'd0) begin
                        n_active = 1'b0;
                    end else if (n_rev == 8'd0) begin
                        hit = 1'b1;
                    end else begin
                        // Nonzero revision: restart the sum for the extended part.
                        n_sum = 8'd0;
                    end
                end else if (rel_x == REL_V2) begin
                    if (n_sum == 8'd0) begin
                        hit  = 1'b1;
                        late = 1'b1;
                    end else begin
                        n_active = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= i_first;
            r_active <= 1'b0;
        end else begin
            if (i_wrap) begin
                r_tok <= i_first;
            end else if (i_adv) begin
                r_tok <= i_tok_prev;
            end
            if (i_kill) begin
                r_active <= 1'b0;
            end else if (i_en) begin
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base   <= cur_base;
            r_sig_ok <= n_sig_ok;
            r_sum    <= n_sum;
            r_rev    <= n_rev;
        end
    end

    assign o_tok      = r_tok;
    assign o_hit.hit  = i_en && hit;
    assign o_hit.late = i_en && late;
    assign o_base     = cur_base;
    assign o_rev      = n_rev;

endmodule

`default_nettype wire

@@ hdl/rsdp_out_buf.sv @@
`default_nettype none

module rsdp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  rsdp_pkg::t_out_req i_res,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output rsdp_pkg::t_out_req o_out
);
    import rsdp_pkg::*;

    logic     r_out_valid;
    t_out_req r_out;
    logic     r_skid_valid;
    t_out_req r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

@@ hdl/rsdp_checker.sv @@
`default_nettype none

module rsdp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input rsdp_pkg::t_out_req o_out
);

    // A stalled result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled result changed");

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output buffer not empty after reset");

    // Input is held off only while a result is waiting at the output.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // A miss reports a zero offset and revision.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.found) |-> (o_out.match_offset == '0 && o_out.revision == 8'd0))
        else $error("miss result carries nonzero fields");

    // A full output buffer stays full while the consumer stalls; input accepted then would be lost.
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && o_valid && i_stall) |=> o_stall)
        else $error("full output buffer drained while stalled");

endmodule

bind acpi_rsdp_stream_scanner rsdp_checker u_rsdp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);

`default_nettype wire

@@ tb/tb_acpi_rsdp_stream_scanner.sv @@
`default_nettype none

module tb_acpi_rsdp_stream_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import rsdp_pkg::*;

    localparam int unsigned POS_W        = OFFSET_BITS_DEF;
    localparam logic [63:0] SIG_WORD     = "RSD PTR ";
    localparam int unsigned LONG_HOLD    = 500;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned IDLE_LIMIT   = 4000;

    typedef enum int unsigned {FLAW_NONE, FLAW_SIG, FLAW_SUM, FLAW_EXT} t_flaw;

    function automatic logic [7:0] sig_char(input logic [2:0] idx);
        return SIG_WORD[8*(7-idx) +: 8];
    endfunction

    class rsdp_scan_scoreboard;
        t_out_req         expected_reports[$];
        int unsigned      mismatches;
        logic [POS_W-1:0] scan_pos;
        bit               trk_live   [TRACKERS];
        logic [POS_W-1:0] trk_base   [TRACKERS];
        bit               trk_sig_ok [TRACKERS];
        logic [7:0]       trk_sum    [TRACKERS];
        logic [7:0]       trk_rev    [TRACKERS];
        bit               matched;

        function new();
            mismatches  = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            scan_pos = '0;
            matched  = 1'b0;
            for (int t = 0; t < TRACKERS; t++) begin
                trk_live[t]   = 1'b0;
                trk_base[t]   = '0;
                trk_sig_ok[t] = 1'b0;
                trk_sum[t]    = '0;
                trk_rev[t]    = '0;
            end
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function void note_byte(t_in_req req);
            logic [POS_W-1:0] rel;
            logic [POS_W-1:0] best_rel;
            int               best;
            int               slot;
            bit               hit;
            t_out_req         rpt;
            best     = -1;
            best_rel = '0;
            rpt      = '0;
            if (!matched) begin
                if (scan_pos % ALIGN_BYTES == 0) begin
                    slot = int'((scan_pos / ALIGN_BYTES) % TRACKERS);
                    trk_live[slot]   = 1'b1;
                    trk_base[slot]   = scan_pos;
                    trk_sig_ok[slot] = 1'b1;
                    trk_sum[slot]    = '0;
                    trk_rev[slot]    = '0;
                end
                for (int t = 0; t < TRACKERS; t++) begin
                    if (trk_live[t]) begin
                        rel = scan_pos - trk_base[t];
                        if (rel >= V2_LEN) begin
                            trk_live[t] = 1'b0;
                        end else begin
                            hit = 1'b0;
                            if (rel < SIG_LEN && req.data_byte != sig_char(rel[2:0]))
                                trk_sig_ok[t] = 1'b0;
                            trk_sum[t] = trk_sum[t] + req.data_byte;
                            if (rel == REV_POS)
                                trk_rev[t] = req.data_byte;
                            if (rel == V1_LEN - 1) begin
                                if (!trk_sig_ok[t] || trk_sum[t] != 0)
                                    trk_live[t] = 1'b0;
                                else if (trk_rev[t] == 0)
                                    hit = 1'b1;
                                else
                                    trk_sum[t] = '0;
                            end else if (rel == V2_LEN - 1) begin
                                if (trk_sum[t] == 0)
                                    hit = 1'b1;
                                else
                                    trk_live[t] = 1'b0;
                            end
                            // A larger distance means the older, lower-offset candidate.
                            if (hit && (best < 0 || rel > best_rel)) begin
                                best     = t;
                                best_rel = rel;
                            end
                        end
                    end
                end
                if (best >= 0) begin
                    rpt.found        = 1'b1;
                    rpt.match_offset = MATCH_W'(trk_base[best]);
                    rpt.revision     = trk_rev[best];
                    expected_reports.push_back(rpt);
                    matched = 1'b1;
                    for (int t = 0; t < TRACKERS; t++)
                        trk_live[t] = 1'b0;
                end
            end
            if (req.last_byte) begin
                if (!matched) begin
                    rpt = '0;
                    expected_reports.push_back(rpt);
                end
                clear_scan();
            end else begin
                scan_pos = scan_pos + 1'b1;
            end
        endfunction

        function void check_report(t_out_req got);
            t_out_req want;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got found=%0d offset=%0d rev=%0d",
                         $time, got.found, got.match_offset, got.revision);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                if (got.found !== want.found) begin
                    $display("%0t: found expected %0d got %0d", $time, want.found, got.found);
                    mismatches++;
                end
                if (got.match_offset !== want.match_offset) begin
                    $display("%0t: match_offset expected %0d got %0d",
                             $time, want.match_offset, got.match_offset);
                    mismatches++;
                end
                if (got.revision !== want.revision) begin
                    $display("%0t: revision expected %0d got %0d",
                             $time, want.revision, got.revision);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_in_req  i_in;
    logic     o_valid;
    logic     i_stall;
    t_out_req o_out;

    rsdp_scan_scoreboard sb;
    logic [7:0]          region_buf[];
    bit                  tx_steady     = 1'b0;
    bit                  rx_steady     = 1'b0;
    bit                  long_hold_req = 1'b0;
    int unsigned         items_sent    = 0;
    int unsigned         idle_cycles   = 0;

    acpi_rsdp_stream_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    always #4ns i_clk = ~i_clk;

    function automatic void fill_region(int unsigned len);
        region_buf = new[len];
        foreach (region_buf[i])
            region_buf[i] = 8'($urandom);
    endfunction

    // Writes a root pointer at the given offset; parts past the region end are dropped.
    function automatic void place_rsdp(int unsigned at, logic [7:0] rev, t_flaw flaw);
        logic [7:0] s[36];
        logic [7:0] acc;
        for (int i = 0; i < 36; i++)
            s[i] = 8'($urandom);
        for (int i = 0; i < 8; i++)
            s[i] = sig_char(3'(i));
        if (flaw == FLAW_SIG)
            s[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
        s[15] = rev;
        acc = '0;
        for (int i = 0; i < 20; i++)
            if (i != 8)
                acc = acc + s[i];
        s[8] = 8'h00 - acc;
        acc = '0;
        for (int i = 20; i < 36; i++)
            if (i != 32)
                acc = acc + s[i];
        s[32] = 8'h00 - acc;
        if (flaw == FLAW_SUM)
            s[8] = s[8] + 8'($urandom_range(1, 255));
        if (flaw == FLAW_EXT)
            s[32] = s[32] + 8'($urandom_range(1, 255));
        for (int i = 0; i < 36; i++)
            if (at + i < region_buf.size())
                region_buf[at + i] = s[i];
    endfunction

    // Called and returns at a falling edge; valid stays high for a back-to-back request.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in    <= '{data_byte: b, last_byte: last};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_byte('{data_byte: b, last_byte: last});
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_region();
        for (int unsigned i = 0; i < region_buf.size(); i++)
            send_byte(region_buf[i], i == region_buf.size() - 1);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned hold;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (rx_steady) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 15);
            end
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            sb.check_report(o_out);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned len;
        int unsigned nplace;
        int unsigned at;
        int unsigned regions;
        logic [7:0]  rev;
        t_flaw       flaw;
        sb      = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-byte regions at both byte extremes: no pointer, found clear.
        region_buf = new[1];
        region_buf[0] = 8'h00;
        send_region();
        region_buf[0] = 8'hFF;
        send_region();
        // Revision zero pointer completing on the last byte.
        fill_region(20);
        place_rsdp(0, 8'h00, FLAW_NONE);
        send_region();
        // Extended pointer completing on the last byte.
        fill_region(36);
        place_rsdp(0, 8'h80, FLAW_NONE);
        send_region();
        // Pointer cut off one byte short by the region end.
        fill_region(19);
        place_rsdp(0, 8'h00, FLAW_NONE);
        send_region();
        wait_idle();

        // Receiver holds off while single-byte regions pile up results.
        long_hold_req = 1'b1;
        tx_steady     = 1'b1;
        for (int i = 0; i < 40; i++) begin
            region_buf = new[1];
            region_buf[0] = 8'($urandom);
            send_region();
        end
        tx_steady = 1'b0;
        wait_idle();

        regions = 0;
        while (items_sent < 900) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 48);
            fill_region(len);
            nplace = $urandom_range(0, 3);
            for (int k = 0; k < nplace; k++) begin
                at = 16 * $urandom_range(0, (len + 15) / 16 - 1);
                if ($urandom_range(0, 7) == 0)
                    at = at + $urandom_range(1, 15);
                if ($urandom_range(0, 1) == 0)
                    rev = 8'h00;
                else if ($urandom_range(0, 3) == 0)
                    rev = 8'hFF;
                else
                    rev = 8'($urandom_range(1, 255));
                flaw = ($urandom_range(0, 3) == 0) ? t_flaw'($urandom_range(1, 3)) : FLAW_NONE;
                place_rsdp(at, rev, flaw);
            end
            tx_steady = ($urandom_range(0, 5) == 0);
            rx_steady = ($urandom_range(0, 5) == 0);
            send_region();
            regions++;
            if (regions % 8 == 0)
                wait_idle();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_idle();

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/rsdp_pkg.sv
hdl/rsdp_cell.sv
hdl/rsdp_out_buf.sv
hdl/acpi_rsdp_stream_scanner.sv
hdl/rsdp_checker.sv
tb/tb_acpi_rsdp_stream_scanner.sv
